@@ sv/tpad_pkg.sv @@
// Shared types and constants of the phase-angle triac dimmer.
`default_nettype none
package tpad_pkg;

	// Item codes
	localparam logic [1:0] OpTick = 2'd0;
	localparam logic [1:0] OpZeroCross = 2'd1;
	localparam logic [1:0] OpKey = 2'd2;

	localparam logic [2:0] KeyEnable = 3'd0;
	localparam logic [2:0] KeyDisable = 3'd1;
	localparam logic [2:0] KeyPlusOne = 3'd2;
	localparam logic [2:0] KeyMinusOne = 3'd3;
	localparam logic [2:0] KeyPlusTen = 3'd4;
	localparam logic [2:0] KeyMinusTen = 3'd5;

	// Firing angle limits and step sizes
	localparam logic [7:0] AngleMin = 8'd10;
	localparam logic [7:0] AngleMax = 8'd170;
	localparam logic [7:0] StepOne = 8'd1;
	localparam logic [7:0] StepTen = 8'd10;
	localparam logic [7:0] AngleUpTenLimit = 8'd160;
	localparam logic [7:0] AngleDownTenLimit = 8'd20;

	// Register map
	localparam int AddrWidth = 3;
	localparam logic RegTicksPerDegree = 1'b0;
	localparam logic RegPulseTicks = 1'b1;
	localparam logic [7:0] TicksPerDegreeReset = 8'd185;
	localparam logic [9:0] PulseTicksReset = 10'd200;

	typedef struct packed {
		logic [1:0] opcode;
		logic [2:0] key_code;
	} in_item_t;

	typedef struct packed {
		logic gate;
		logic [7:0] angle;
		logic enabled;
	} out_item_t;

	// Configuration values handed to the control core
	typedef struct packed {
		logic [7:0] ticks_per_degree;
		logic [9:0] pulse_ticks;
	} cfg_t;

endpackage
`default_nettype wire

@@ sv/triac_phase_angle_dimmer.sv @@
// A transaction is held in the input register, then the result register.
// Throughput: one transaction per cycle unless out_ready stalls; the state update
// for each item is a single pass of logic between the input and result registers.
// Reset: arst_n clears the pipeline, the angle to 170, the flag, delay and pulse,
// and loads ticks_per_degree 185 and pulse_ticks 200.
`default_nettype none
module triac_phase_angle_dimmer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire tpad_pkg::in_item_t in_item,
	output logic out_valid,
	input wire logic out_ready,
	output tpad_pkg::out_item_t out_item,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [tpad_pkg::AddrWidth-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	tpad_pkg::in_item_t item_s1;
	logic valid_s1;
	tpad_pkg::out_item_t result;
	tpad_pkg::out_item_t out_q;
	logic out_valid_q;
	tpad_pkg::cfg_t cfg_q;
	logic advance;
	logic cfg_write;

	// The input stage moves on whenever the result register is empty or being drained.
	assign advance = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance) out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= in_item;
		if (advance && valid_s1) out_q <= result;
	end

	tpad_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance && valid_s1),
		.item(item_s1),
		.cfg(cfg_q),
		.result(result)
	);

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_degree <= tpad_pkg::TicksPerDegreeReset;
			cfg_q.pulse_ticks <= tpad_pkg::PulseTicksReset;
		end else if (cfg_write) begin
			case (paddr[2])
				tpad_pkg::RegTicksPerDegree: cfg_q.ticks_per_degree <= pwdata[7:0];
				tpad_pkg::RegPulseTicks: cfg_q.pulse_ticks <= pwdata[9:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			tpad_pkg::RegTicksPerDegree: prdata = {24'd0, cfg_q.ticks_per_degree};
			tpad_pkg::RegPulseTicks: prdata = {22'd0, cfg_q.pulse_ticks};
			default: prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

@@ sv/tpad_core.sv @@
// Dimmer state registers and the next-state logic for one transaction.
`default_nettype none
module tpad_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire tpad_pkg::in_item_t item,
	input wire tpad_pkg::cfg_t cfg,
	output tpad_pkg::out_item_t result
);

	logic [7:0] angle_q, angle_d;
	logic active_q, active_d;
	logic [15:0] delay_q, delay_d;
	logic pending_q, pending_d;
	logic [9:0] pulse_q, pulse_d;
	logic gate_q, gate_d;

	always_comb begin
		angle_d = angle_q;
		active_d = active_q;
		delay_d = delay_q;
		pending_d = pending_q;
		pulse_d = pulse_q;
		gate_d = gate_q;
		case (item.opcode)
			tpad_pkg::OpTick: begin
				if (gate_q) begin
					if (pulse_q[9:1] == 9'd0) begin
						gate_d = 1'b0;
						pulse_d = 10'd0;
					end else begin
						pulse_d = pulse_q - 10'd1;
					end
				end else if (pending_q) begin
					if (delay_q[15:1] == 15'd0) begin
						pending_d = 1'b0;
						delay_d = 16'd0;
						gate_d = 1'b1;
						pulse_d = cfg.pulse_ticks;
					end else begin
						delay_d = delay_q - 16'd1;
					end
				end
			end
			tpad_pkg::OpZeroCross: begin
				// The product never exceeds 170 * 255, so 16 bits hold it.
				delay_d = 16'(angle_q) * 16'(cfg.ticks_per_degree);
				pending_d = 1'b1;
				gate_d = 1'b0;
				pulse_d = 10'd0;
			end
			tpad_pkg::OpKey: begin
				case (item.key_code)
					tpad_pkg::KeyEnable: begin
						if (!active_q) begin
							active_d = 1'b1;
							angle_d = tpad_pkg::AngleMin;
						end
					end
					tpad_pkg::KeyDisable: begin
						if (active_q) begin
							active_d = 1'b0;
							angle_d = tpad_pkg::AngleMax;
						end
					end
					tpad_pkg::KeyPlusOne: begin
						if (angle_q < tpad_pkg::AngleMax) angle_d = angle_q + tpad_pkg::StepOne;
					end
					tpad_pkg::KeyMinusOne: begin
						if (angle_q > tpad_pkg::AngleMin) angle_d = angle_q - tpad_pkg::StepOne;
					end
					tpad_pkg::KeyPlusTen: begin
						if (angle_q <= tpad_pkg::AngleUpTenLimit) begin
							angle_d = angle_q + tpad_pkg::StepTen;
						end
					end
					tpad_pkg::KeyMinusTen: begin
						if (angle_q >= tpad_pkg::AngleDownTenLimit) begin
							angle_d = angle_q - tpad_pkg::StepTen;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= tpad_pkg::AngleMax;
			active_q <= 1'b0;
			delay_q <= 16'd0;
			pending_q <= 1'b0;
			pulse_q <= 10'd0;
			gate_q <= 1'b0;
		end else if (step) begin
			angle_q <= angle_d;
			active_q <= active_d;
			delay_q <= delay_d;
			pending_q <= pending_d;
			pulse_q <= pulse_d;
			gate_q <= gate_d;
		end
	end

	assign result.gate = gate_d;
	assign result.angle = angle_d;
	assign result.enabled = active_d;

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle_q >= tpad_pkg::AngleMin && angle_q <= tpad_pkg::AngleMax)
		else $error("firing angle left its range");

	a_gate_excl_delay: assert property (@(posedge clk) disable iff (!arst_n)
		!(gate_q && pending_q))
		else $error("gate pulse and delay active together");

	a_zero_cross: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.opcode == tpad_pkg::OpZeroCross |=> pending_q && !gate_q)
		else $error("zero crossing did not start a delay");

	a_enable_angle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(active_q) |-> angle_q == tpad_pkg::AngleMin)
		else $error("enable did not set the minimum angle");

endmodule
`default_nettype wire
